// ===== hdl/wlpc_pkg.sv =====
`default_nettype none

package wlpc_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int PT_W       = FRAC_BITS + 1;
    localparam int SAMPLE_W   = 32;
    localparam int DIFF_W     = SAMPLE_W + 1;
    localparam int CNT_W      = 5;
    localparam int SLOT_W     = 4;
    localparam int CH_W       = 2;
    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DEF_POINTS = 16;

    // interpolation divide: 9 quotient bits cover up to twice full scale
    localparam int QN_W   = 9;
    localparam int NUM_W  = PT_W + QN_W;
    localparam int PROD_W = 2 * PT_W;

    localparam logic [PT_W-1:0] ONE = PT_W'(1) << FRAC_BITS;

    localparam logic CMD_MAP  = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    localparam logic [CH_W-1:0] CH_RED   = 2'd0;
    localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
    localparam logic [CH_W-1:0] CH_BLUE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_HIST_MIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIST_MAX    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RED_COUNT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_COUNT  = 3'd4;

    typedef struct packed {
        logic              cmd;
        logic              ok;
        logic [CH_W-1:0]   ch;
        logic [SLOT_W-1:0] slot;
        logic [PT_W-1:0]   x;
        logic [PT_W-1:0]   y;
    } item_t;

endpackage

`default_nettype wire

// ===== hdl/wlpc_in_if.sv =====
`default_nettype none

interface wlpc_in_if;
    logic                                valid;
    logic                                ready;
    logic                                command;
    logic signed [wlpc_pkg::SAMPLE_W-1:0] sample;
    logic                                sample_ok;
    logic [wlpc_pkg::CH_W-1:0]           channel;
    logic [wlpc_pkg::SLOT_W-1:0]         point_slot;
    logic [wlpc_pkg::PT_W-1:0]           point_x;
    logic [wlpc_pkg::PT_W-1:0]           point_y;

    modport source (output valid, command, sample, sample_ok, channel, point_slot,
                    point_x, point_y, input ready);
    modport sink (input valid, command, sample, sample_ok, channel, point_slot,
                  point_x, point_y, output ready);
endinterface

`default_nettype wire

// ===== hdl/wlpc_out_if.sv =====
`default_nettype none

interface wlpc_out_if;
    logic                       valid;
    logic                       ready;
    logic [wlpc_pkg::PIX_W-1:0] red;
    logic [wlpc_pkg::PIX_W-1:0] green;
    logic [wlpc_pkg::PIX_W-1:0] blue;
    logic                       opaque;

    modport source (output valid, red, green, blue, opaque, input ready);
    modport sink (input valid, red, green, blue, opaque, output ready);
endinterface

`default_nettype wire

// ===== hdl/window_level_pwl_colormap_core.sv =====
`default_nettype none

// Window/level colour map. Each map item gives one RGB pixel; a load item
// writes one breakpoint and gives nothing. One item enters per clock unless
// a stall holds it; a stall holds the whole pipeline. An item passes the front
// register, window divide, t register, curve stages, interpolation divide and
// output register. Loads take effect for every later map item.
// Breakpoints are not cleared by reset: load every slot in use before mapping.
module window_level_pwl_colormap_core #(
    parameter int POINTS = wlpc_pkg::DEF_POINTS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [wlpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wlpc_pkg::CFG_DATA_W-1:0]     cfg_data,
    wlpc_in_if.sink                             samples,
    wlpc_out_if.source                          pixels
);

    localparam int CUR_STAGES = 3;
    localparam int NW = wlpc_pkg::NUM_W;
    localparam int PW = wlpc_pkg::PT_W;
    localparam int QW = wlpc_pkg::QN_W;

    logic signed [wlpc_pkg::SAMPLE_W-1:0] hist_min_reg, hist_max_reg;
    logic [wlpc_pkg::CNT_W-1:0]           count_reg [3];

    logic                  adv;
    wlpc_pkg::item_t       in_item;
    logic                  t_valid;
    wlpc_pkg::item_t       t_item;
    logic [PW-1:0]         t;

    logic [NW-1:0]         cur_num [3];
    logic [PW-1:0]         cur_dx  [3];
    logic [NW-QW-1:0]      div_hi  [3];
    logic [QW-1:0]         div_lo  [3];
    logic [QW-1:0]         div_q   [3];

    logic                  cv_reg  [CUR_STAGES];
    logic                  cmap_reg[CUR_STAGES];
    logic                  cok_reg [CUR_STAGES];

    logic                  div_valid;
    logic                  div_ok;

    logic                  out_valid_reg;
    logic [wlpc_pkg::PIX_W-1:0] out_pix_reg [3];
    logic                  out_opaque_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_min_reg <= '0;
            hist_max_reg <= 32'sd65536;
            count_reg[0] <= '0;
            count_reg[1] <= '0;
            count_reg[2] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wlpc_pkg::REG_HIST_MIN:    hist_min_reg <= cfg_data;
                wlpc_pkg::REG_HIST_MAX:    hist_max_reg <= cfg_data;
                wlpc_pkg::REG_RED_COUNT:   count_reg[0] <= cfg_data[wlpc_pkg::CNT_W-1:0];
                wlpc_pkg::REG_GREEN_COUNT: count_reg[1] <= cfg_data[wlpc_pkg::CNT_W-1:0];
                wlpc_pkg::REG_BLUE_COUNT:  count_reg[2] <= cfg_data[wlpc_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign adv           = !out_valid_reg || pixels.ready;
    assign samples.ready = adv;

    assign in_item.cmd  = samples.command;
    assign in_item.ok   = samples.sample_ok;
    assign in_item.ch   = samples.channel;
    assign in_item.slot = samples.point_slot;
    assign in_item.x    = samples.point_x;
    assign in_item.y    = samples.point_y;

    wlpc_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (samples.valid),
        .in_item   (in_item),
        .sample    (samples.sample),
        .hist_min  (hist_min_reg),
        .hist_max  (hist_max_reg),
        .out_valid (t_valid),
        .out_item  (t_item),
        .t         (t)
    );

    genvar c;
    for (c = 0; c < 3; c++)
    begin : g_chan
        wlpc_curve #(
            .POINTS (POINTS),
            .CHAN   (wlpc_pkg::CH_W'(c))
        ) u_curve (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .in_valid (t_valid),
            .in_item  (t_item),
            .t        (t),
            .count    (count_reg[c]),
            .num      (cur_num[c]),
            .dx       (cur_dx[c])
        );
        assign div_hi[c] = cur_num[c][NW-1:QW];
        assign div_lo[c] = cur_num[c][QW-1:0];
    end

    // item tags alongside the curve stages; loads leave here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CUR_STAGES; i++)
                cv_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            cv_reg[0] <= t_valid;
            for (int i = 1; i < CUR_STAGES; i++)
                cv_reg[i] <= cv_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmap_reg[0] <= t_item.cmd == wlpc_pkg::CMD_MAP;
            cok_reg[0]  <= t_item.ok;
            for (int i = 1; i < CUR_STAGES; i++)
            begin
                cmap_reg[i] <= cmap_reg[i-1];
                cok_reg[i]  <= cok_reg[i-1];
            end
        end
    end

    wlpc_div #(
        .SW (PW),
        .QW (QW),
        .LN (3),
        .PW (1)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (cv_reg[CUR_STAGES-1] && cmap_reg[CUR_STAGES-1]),
        .in_hi     (div_hi),
        .in_lo     (div_lo),
        .in_dsor   (cur_dx),
        .in_pay    (cok_reg[CUR_STAGES-1]),
        .out_valid (div_valid),
        .out_q     (div_q),
        .out_pay   (div_ok)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_opaque_reg <= div_ok;
            for (int i = 0; i < 3; i++)
            begin
                if (!div_ok)
                    out_pix_reg[i] <= '0;
                else if (div_q[i][QW-1])
                    out_pix_reg[i] <= '1;
                else
                    out_pix_reg[i] <= div_q[i][wlpc_pkg::PIX_W-1:0];
            end
        end
    end

    assign pixels.valid  = out_valid_reg;
    assign pixels.red    = out_pix_reg[0];
    assign pixels.green  = out_pix_reg[1];
    assign pixels.blue   = out_pix_reg[2];
    assign pixels.opaque = out_opaque_reg;

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> samples.ready)
        else $error("input held off with empty output register");

endmodule

`default_nettype wire

// ===== hdl/wlpc_div.sv =====
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage, LN lanes in step.
// Dividend is {hi, lo}; hi must be below the divisor for a valid quotient.
module wlpc_div #(
    parameter int SW = 17,
    parameter int QW = 9,
    parameter int LN = 1,
    parameter int PW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  logic [SW-1:0] in_hi   [LN],
    input  logic [QW-1:0] in_lo   [LN],
    input  logic [SW-1:0] in_dsor [LN],
    input  logic [PW-1:0] in_pay,
    output logic          out_valid,
    output logic [QW-1:0] out_q   [LN],
    output logic [PW-1:0] out_pay
);

    logic          vld_reg  [QW];
    logic [PW-1:0] pay_reg  [QW];
    logic [SW-1:0] rem_reg  [QW][LN];
    logic [QW-1:0] low_reg  [QW][LN];
    logic [QW-1:0] q_reg    [QW][LN];
    logic [SW-1:0] dsor_reg [QW][LN];

    logic          vld_in  [QW];
    logic [PW-1:0] pay_in  [QW];
    logic [SW-1:0] rem_in  [QW][LN];
    logic [QW-1:0] low_in  [QW][LN];
    logic [QW-1:0] q_in    [QW][LN];
    logic [SW-1:0] dsor_in [QW][LN];

    genvar k, l;
    for (k = 0; k < QW; k++)
    begin : g_stage
        if (k == 0)
        begin : g_head
            assign vld_in[k] = in_valid;
            assign pay_in[k] = in_pay;
            for (l = 0; l < LN; l++)
            begin : g_src
                assign rem_in[k][l]  = in_hi[l];
                assign low_in[k][l]  = in_lo[l];
                assign q_in[k][l]    = '0;
                assign dsor_in[k][l] = in_dsor[l];
            end
        end
        else
        begin : g_body
            assign vld_in[k] = vld_reg[k-1];
            assign pay_in[k] = pay_reg[k-1];
            for (l = 0; l < LN; l++)
            begin : g_src
                assign rem_in[k][l]  = rem_reg[k-1][l];
                assign low_in[k][l]  = low_reg[k-1][l];
                assign q_in[k][l]    = q_reg[k-1][l];
                assign dsor_in[k][l] = dsor_reg[k-1][l];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (adv)
                vld_reg[k] <= vld_in[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                pay_reg[k] <= pay_in[k];
        end

        for (l = 0; l < LN; l++)
        begin : g_lane
            logic [SW:0] r2;
            logic [SW:0] diff;
            logic        ge;

            assign r2   = {rem_in[k][l], low_in[k][l][QW-1]};
            assign diff = r2 - {1'b0, dsor_in[k][l]};
            assign ge   = r2 >= {1'b0, dsor_in[k][l]};

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[k][l]  <= ge ? diff[SW-1:0] : r2[SW-1:0];
                    low_reg[k][l]  <= low_in[k][l] << 1;
                    q_reg[k][l]    <= {q_in[k][l][QW-2:0], ge};
                    dsor_reg[k][l] <= dsor_in[k][l];
                end
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign out_pay   = pay_reg[QW-1];
    for (l = 0; l < LN; l++)
    begin : g_out
        assign out_q[l] = q_reg[QW-1][l];
    end

endmodule

`default_nettype wire

// ===== hdl/wlpc_norm.sv =====
`default_nettype none

// Window clamp and normalisation to t in [0, ONE].
module wlpc_norm (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 adv,
    input  logic                                 in_valid,
    input  wlpc_pkg::item_t                      in_item,
    input  logic signed [wlpc_pkg::SAMPLE_W-1:0] sample,
    input  logic signed [wlpc_pkg::SAMPLE_W-1:0] hist_min,
    input  logic signed [wlpc_pkg::SAMPLE_W-1:0] hist_max,
    output logic                                 out_valid,
    output wlpc_pkg::item_t                      out_item,
    output logic [wlpc_pkg::PT_W-1:0]            t
);

    localparam int DW = wlpc_pkg::DIFF_W;
    localparam int FB = wlpc_pkg::FRAC_BITS;
    localparam int PW = $bits(wlpc_pkg::item_t) + 2;

    logic                  a_valid_reg;
    wlpc_pkg::item_t       a_item_reg;
    logic [DW-1:0]         a_diff_reg;
    logic [DW-1:0]         a_dsor_reg;
    logic                  a_low_reg;
    logic                  a_high_reg;

    logic [DW-1:0]         div_hi   [1];
    logic [FB-1:0]         div_lo   [1];
    logic [DW-1:0]         div_dsor [1];
    logic [FB-1:0]         div_q    [1];
    logic                  div_valid;
    logic [PW-1:0]         div_pay;
    wlpc_pkg::item_t       div_item;
    logic                  div_low;
    logic                  div_high;

    logic                  t_valid_reg;
    wlpc_pkg::item_t       t_item_reg;
    logic [wlpc_pkg::PT_W-1:0] t_reg;
    logic [wlpc_pkg::PT_W-1:0] t_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (adv)
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_item_reg <= in_item;
            a_diff_reg <= {sample[wlpc_pkg::SAMPLE_W-1], sample}
                        - {hist_min[wlpc_pkg::SAMPLE_W-1], hist_min};
            a_dsor_reg <= {hist_max[wlpc_pkg::SAMPLE_W-1], hist_max}
                        - {hist_min[wlpc_pkg::SAMPLE_W-1], hist_min};
            a_low_reg  <= sample <= hist_min;
            a_high_reg <= sample >= hist_max;
        end
    end

    assign div_hi[0]   = a_diff_reg;
    assign div_lo[0]   = '0;
    assign div_dsor[0] = a_dsor_reg;

    wlpc_div #(
        .SW (DW),
        .QW (FB),
        .LN (1),
        .PW (PW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (a_valid_reg),
        .in_hi     (div_hi),
        .in_lo     (div_lo),
        .in_dsor   (div_dsor),
        .in_pay    ({a_item_reg, a_low_reg, a_high_reg}),
        .out_valid (div_valid),
        .out_q     (div_q),
        .out_pay   (div_pay)
    );

    assign {div_item, div_low, div_high} = div_pay;

    // below the window wins over above it (inverted window case)
    always_comb
    begin
        if (div_low)
            t_next = '0;
        else if (div_high)
            t_next = wlpc_pkg::ONE;
        else
            t_next = {1'b0, div_q[0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t_valid_reg <= 1'b0;
        else if (adv)
            t_valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_item_reg <= div_item;
            t_reg      <= t_next;
        end
    end

    assign out_valid = t_valid_reg;
    assign out_item  = t_item_reg;
    assign t         = t_reg;

    a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
        t_valid_reg && !t_item_reg.cmd |-> t_reg <= wlpc_pkg::ONE)
        else $error("normalised t above one");

endmodule

`default_nettype wire

// ===== hdl/wlpc_curve.sv =====
`default_nettype none

// One colour curve: breakpoint store, segment pick, products, scaled numerator.
module wlpc_curve #(
    parameter int              POINTS = wlpc_pkg::DEF_POINTS,
    parameter logic [wlpc_pkg::CH_W-1:0] CHAN = wlpc_pkg::CH_RED
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  logic                           in_valid,
    input  wlpc_pkg::item_t                in_item,
    input  logic [wlpc_pkg::PT_W-1:0]      t,
    input  logic [wlpc_pkg::CNT_W-1:0]     count,
    output logic [wlpc_pkg::NUM_W-1:0]     num,
    output logic [wlpc_pkg::PT_W-1:0]      dx
);

    localparam int IDX_W = $clog2(POINTS);
    localparam int PW    = wlpc_pkg::PT_W;
    localparam int PRW   = wlpc_pkg::PROD_W;

    logic [PW-1:0]      x_reg [POINTS];
    logic [PW-1:0]      y_reg [POINTS];

    logic               wr;
    logic [IDX_W:0]     nsat;
    logic [POINTS-1:0]  le, lt, rng, last, mseg, first, pick;
    logic               flat, empty, ge_last;
    logic [PW-1:0]      xa, xb, ya, yb;
    logic [PW-1:0]      c_y0_next, c_y1_next, c_a_next, c_b_next, c_dx_next;

    logic [PW-1:0]      c_y0_reg, c_y1_reg, c_a_reg, c_b_reg, c_dx_reg;
    logic [PRW-1:0]     m_p0_reg, m_p1_reg;
    logic [PW-1:0]      m_dx_reg;
    logic [PRW:0]       sum;
    logic [PRW+8:0]     scaled;
    logic [wlpc_pkg::NUM_W-1:0] n_num_reg;
    logic [PW-1:0]      n_dx_reg;

    // loads land here, in item order with the maps that read the store
    assign wr = adv && in_valid && in_item.cmd == wlpc_pkg::CMD_LOAD
             && in_item.ch == CHAN && 32'(in_item.slot) < POINTS;

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            x_reg[IDX_W'(in_item.slot)] <= in_item.x;
            y_reg[IDX_W'(in_item.slot)] <= in_item.y;
        end
    end

    assign nsat = (32'(count) > POINTS) ? (IDX_W+1)'(POINTS) : (IDX_W+1)'(count);

    always_comb
    begin
        for (int i = 0; i < POINTS; i++)
        begin
            le[i]   = t <= x_reg[i];
            lt[i]   = t < x_reg[i];
            rng[i]  = (IDX_W+1)'(i) < nsat;
            last[i] = (IDX_W+1)'(i + 1) == nsat;
        end
        mseg    = le & rng & ~POINTS'(1);
        first   = mseg & (~mseg + POINTS'(1));
        ge_last = |(last & ~lt);
        empty   = nsat == '0;
        flat    = le[0] || ge_last;
        if (le[0])
            pick = POINTS'(1);
        else if (ge_last)
            pick = last;
        else
            pick = first;

        xa = '0;
        xb = '0;
        ya = '0;
        yb = '0;
        for (int i = 0; i < POINTS; i++)
        begin
            if (pick[i])
            begin
                xb = xb | x_reg[i];
                yb = yb | y_reg[i];
                if (i > 0)
                begin
                    xa = xa | x_reg[i-1];
                    ya = ya | y_reg[i-1];
                end
            end
        end

        // flat ends and empty curve use a unit segment with the weight on y1
        if (empty || flat)
        begin
            c_y0_next = '0;
            c_y1_next = empty ? '0 : yb;
            c_a_next  = '0;
            c_b_next  = PW'(1);
            c_dx_next = PW'(1);
        end
        else
        begin
            c_y0_next = ya;
            c_y1_next = yb;
            c_a_next  = xb - t;
            c_b_next  = t - xa;
            c_dx_next = xb - xa;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_y0_reg  <= c_y0_next;
            c_y1_reg  <= c_y1_next;
            c_a_reg   <= c_a_next;
            c_b_reg   <= c_b_next;
            c_dx_reg  <= c_dx_next;

            m_p0_reg  <= c_y0_reg * c_a_reg;
            m_p1_reg  <= c_y1_reg * c_b_reg;
            m_dx_reg  <= c_dx_reg;

            n_num_reg <= scaled[wlpc_pkg::NUM_W+wlpc_pkg::FRAC_BITS-1:wlpc_pkg::FRAC_BITS];
            n_dx_reg  <= m_dx_reg;
        end
    end

    // 255 * sum, then drop the fraction of ONE (floor nests through the divide)
    assign sum    = {1'b0, m_p0_reg} + {1'b0, m_p1_reg};
    assign scaled = {sum, 8'd0} - {8'd0, sum};

    assign num = n_num_reg;
    assign dx  = n_dx_reg;

    a_pick_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_item.cmd == wlpc_pkg::CMD_MAP |-> $onehot0(pick))
        else $error("more than one segment picked");

    a_dx_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        adv && in_valid && in_item.cmd == wlpc_pkg::CMD_MAP |=> c_dx_reg != '0)
        else $error("zero segment width");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none

module tb_top;

    localparam int SAMPLE_W   = wlpc_pkg::SAMPLE_W;
    localparam int CH_W       = wlpc_pkg::CH_W;
    localparam int SLOT_W     = wlpc_pkg::SLOT_W;
    localparam int PT_W       = wlpc_pkg::PT_W;
    localparam int PIX_W      = wlpc_pkg::PIX_W;
    localparam int CNT_W      = wlpc_pkg::CNT_W;
    localparam int CFG_IDX_W  = wlpc_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = wlpc_pkg::CFG_DATA_W;
    localparam int FRAC_BITS  = wlpc_pkg::FRAC_BITS;
    localparam logic [PT_W-1:0] ONE = wlpc_pkg::ONE;
    localparam logic CMD_MAP  = wlpc_pkg::CMD_MAP;
    localparam logic CMD_LOAD = wlpc_pkg::CMD_LOAD;
    localparam logic [CH_W-1:0] CH_RED  = wlpc_pkg::CH_RED;
    localparam logic [CH_W-1:0] CH_BLUE = wlpc_pkg::CH_BLUE;
    localparam logic [CFG_IDX_W-1:0] REG_HIST_MIN   = wlpc_pkg::REG_HIST_MIN;
    localparam logic [CFG_IDX_W-1:0] REG_HIST_MAX   = wlpc_pkg::REG_HIST_MAX;
    localparam logic [CFG_IDX_W-1:0] REG_RED_COUNT  = wlpc_pkg::REG_RED_COUNT;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_COUNT = wlpc_pkg::REG_GREEN_COUNT;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_COUNT = wlpc_pkg::REG_BLUE_COUNT;

    localparam int NPTS        = wlpc_pkg::DEF_POINTS;
    localparam int LATENCY     = 31;
    localparam int SETTLE      = LATENCY + 20;
    localparam int CYCLE_LIMIT = 600000;
    localparam int MAX_REPORTS = 10;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = REG_BLUE_COUNT + 3'd1;

    typedef struct packed {
        logic                cmd;
        logic [SAMPLE_W-1:0] sample;
        logic                ok;
        logic [CH_W-1:0]     ch;
        logic [SLOT_W-1:0]   slot;
        logic [PT_W-1:0]     x;
        logic [PT_W-1:0]     y;
    } cmd_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             opaque;
    } pixel_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    wlpc_in_if  samples ();
    wlpc_out_if pixels ();

    window_level_pwl_colormap_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (samples.sink),
        .pixels    (pixels.source)
    );

    // predictor state
    longint          win_lo;
    longint          win_hi;
    int unsigned     curve_len [3];
    longint unsigned knot_x [3][NPTS];
    longint unsigned knot_y [3][NPTS];

    pixel_t pixel_q [$];
    int     errors;
    int     send_idle;
    int     recv_idle;
    int     hold_cycles;
    int     cycles;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    function automatic longint unsigned to_level(longint unsigned num, longint unsigned den);
        longint unsigned r;
        r = (255 * num) / den;
        return (r > 255) ? 255 : r;
    endfunction

    function automatic longint unsigned window_pos(longint s);
        if (s <= win_lo)
            return 0;
        if (s >= win_hi)
            return longint'(ONE);
        return (unsigned'(s - win_lo) << FRAC_BITS) / unsigned'(win_hi - win_lo);
    endfunction

    function automatic logic [PIX_W-1:0] curve_level(int c, longint unsigned t);
        int unsigned n;
        longint unsigned x0, x1, num;
        n = (curve_len[c] > NPTS) ? NPTS : curve_len[c];
        if (n == 0)
            return '0;
        if (t <= knot_x[c][0])
            return PIX_W'(to_level(knot_y[c][0], longint'(ONE)));
        if (t >= knot_x[c][n-1])
            return PIX_W'(to_level(knot_y[c][n-1], longint'(ONE)));
        for (int i = 1; i < n; i++)
        begin
            if (t <= knot_x[c][i])
            begin
                x0 = knot_x[c][i-1];
                x1 = knot_x[c][i];
                num = knot_y[c][i-1] * (x1 - t) + knot_y[c][i] * (t - x0);
                return PIX_W'(to_level(num, (x1 - x0) * longint'(ONE)));
            end
        end
        return '0;
    endfunction

    task automatic predict_item(cmd_item_t it);
        pixel_t p;
        longint unsigned t;
        if (it.cmd == CMD_LOAD)
        begin
            if (it.ch != 2'd3)
            begin
                knot_x[it.ch][it.slot] = it.x;
                knot_y[it.ch][it.slot] = it.y;
            end
        end
        else
        begin
            p = '0;
            if (it.ok)
            begin
                t = window_pos(longint'(signed'(it.sample)));
                p.red    = curve_level(0, t);
                p.green  = curve_level(1, t);
                p.blue   = curve_level(2, t);
                p.opaque = 1'b1;
            end
            pixel_q.insert(pixel_q.size(), p);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        pixel_t got, want;
        if (pixels.valid && pixels.ready)
        begin
            got = '{pixels.red, pixels.green, pixels.blue, pixels.opaque};
            if (pixel_q.size() == 0)
            begin
                errors = errors + 1;
                if (errors <= MAX_REPORTS)
                    $display("unexpected pixel %h", got);
            end
            else
            begin
                want = pixel_q.pop_front();
                if (got !== want)
                begin
                    errors = errors + 1;
                    if (errors <= MAX_REPORTS)
                        $display("pixel mismatch: expected r%0d g%0d b%0d a%0d, got r%0d g%0d b%0d a%0d",
                                 want.red, want.green, want.blue, want.opaque,
                                 got.red, got.green, got.blue, got.opaque);
                end
            end
        end
    end

    // receiver back-pressure, with long holds counted here
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            pixels.ready <= 1'b0;
        end
        else
            pixels.ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic send_item(cmd_item_t it);
        @(posedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            samples.valid <= 1'b0;
            @(posedge clk);
        end
        samples.valid      <= 1'b1;
        samples.command    <= it.cmd;
        samples.sample     <= it.sample;
        samples.sample_ok  <= it.ok;
        samples.channel    <= it.ch;
        samples.point_slot <= it.slot;
        samples.point_x    <= it.x;
        samples.point_y    <= it.y;
        do
            @(posedge clk);
        while (!samples.ready);
        predict_item(it);
        samples.valid <= 1'b0;
    endtask

    task automatic map_sample(logic [SAMPLE_W-1:0] s, logic ok);
        cmd_item_t it;
        it = '{cmd: CMD_MAP, sample: s, ok: ok, ch: CH_W'($urandom),
               slot: SLOT_W'($urandom), x: PT_W'($urandom), y: PT_W'($urandom)};
        send_item(it);
    endtask

    task automatic load_point(logic [CH_W-1:0] c, logic [SLOT_W-1:0] s,
                              logic [PT_W-1:0] x, logic [PT_W-1:0] y);
        cmd_item_t it;
        it = '{cmd: CMD_LOAD, sample: SAMPLE_W'($urandom), ok: 1'($urandom),
               ch: c, slot: s, x: x, y: y};
        send_item(it);
    endtask

    // whole curve with ascending x; occasionally x and y beyond one
    task automatic load_curve(logic [CH_W-1:0] c);
        int xs [$];
        int wide;
        wide = ($urandom_range(5) == 0);
        for (int i = 0; i < NPTS; i++)
            xs.insert(xs.size(), wide ? $urandom_range(131071) : $urandom_range(65536));
        xs.sort();
        for (int i = 0; i < NPTS; i++)
            load_point(c, SLOT_W'(i), PT_W'(xs[i]),
                       PT_W'(wide ? $urandom_range(131071) : $urandom_range(65536)));
    endtask

    task automatic wait_idle();
        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_HIST_MIN)
            win_lo = longint'(signed'(val));
        else if (idx == REG_HIST_MAX)
            win_hi = longint'(signed'(val));
        else if (idx >= REG_RED_COUNT && idx <= REG_BLUE_COUNT)
            curve_len[idx - REG_RED_COUNT] = val[CNT_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_window(longint lo, longint hi);
        write_reg(REG_HIST_MIN, CFG_DATA_W'(lo));
        write_reg(REG_HIST_MAX, CFG_DATA_W'(hi));
    endtask

    task automatic set_counts(int r, int g, int b);
        write_reg(REG_RED_COUNT,   {$urandom} & ~32'h1f | 32'(r));
        write_reg(REG_GREEN_COUNT, {$urandom} & ~32'h1f | 32'(g));
        write_reg(REG_BLUE_COUNT,  {$urandom} & ~32'h1f | 32'(b));
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        longint w;
        longint unsigned r;
        w = win_hi - win_lo;
        r = {$urandom, $urandom};
        case ($urandom_range(9))
            0, 1:    return $urandom;
            2:       return SAMPLE_W'(win_lo + $urandom_range(6) - 3);
            3:       return SAMPLE_W'(win_hi + $urandom_range(6) - 3);
            4:       return ($urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff);
            default: return (w > 0) ? SAMPLE_W'(win_lo + longint'(r % unsigned'(w + 1)))
                                    : SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic random_traffic(int n);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(19))
                0, 1:    load_point(CH_W'($urandom), SLOT_W'($urandom),
                                    PT_W'($urandom), PT_W'($urandom));
                2:       map_sample(SAMPLE_W'($urandom), 1'b0);
                default: map_sample(pick_sample(), 1'b1);
            endcase
        end
    endtask

    task automatic random_setting();
        case ($urandom_range(4))
            0:       set_window(-64'sd2147483648, 64'sd2147483647);
            1:       set_window($urandom_range(200) - 100, $urandom_range(200) - 100);
            2:       set_window(longint'(signed'(32'($urandom))), longint'(signed'(32'($urandom))));
            default:
            begin
                win_lo = longint'(signed'(32'($urandom))) >>> $urandom_range(20);
                set_window(win_lo, win_lo + $urandom_range(1 << $urandom_range(24)));
            end
        endcase
        if ($urandom_range(3) == 0)
            set_counts($urandom_range(31), $urandom_range(31), $urandom_range(31));
        else
            set_counts($urandom_range(NPTS), $urandom_range(NPTS), $urandom_range(NPTS));
        if ($urandom_range(1))
            write_reg(REG_SPARE + CFG_IDX_W'($urandom_range(2)), $urandom);
    endtask

    task automatic test_directed();
        for (int c = 0; c < 3; c++)
            load_curve(CH_W'(c));
        wait_idle();
        set_counts(NPTS, NPTS, NPTS);
        map_sample(32'h8000_0000, 1'b1);
        map_sample(32'h7fff_ffff, 1'b1);
        map_sample(32'd0, 1'b1);
        map_sample(32'd65536, 1'b1);
        map_sample(32'd32768, 1'b1);
        map_sample(32'hffff_ffff, 1'b0);
        map_sample(32'd12345, 1'b0);
        wait_idle();
        // inverted window, then empty window
        set_window(100, -100);
        map_sample(-32'sd200, 1'b1);
        map_sample(32'd0, 1'b1);
        map_sample(32'd200, 1'b1);
        wait_idle();
        set_window(5, 5);
        map_sample(32'd4, 1'b1);
        map_sample(32'd5, 1'b1);
        map_sample(32'd6, 1'b1);
        wait_idle();
        // empty red, saturated green count, two-point blue
        set_window(-64'sd2147483648, 64'sd2147483647);
        set_counts(0, 31, 2);
        load_point(CH_BLUE, 4'd0, 17'd0, 17'd131071);
        load_point(CH_BLUE, 4'd1, 17'd131071, 17'd0);
        map_sample(32'h8000_0000, 1'b1);
        map_sample(32'h0000_0000, 1'b1);
        map_sample(32'h7fff_ffff, 1'b1);
        load_point(2'd3, 4'd0, 17'd0, 17'd0);
        map_sample(32'h4000_0000, 1'b1);
        wait_idle();
        write_reg(REG_SPARE, 32'hffff_ffff);
    endtask

    task automatic test_random_phase(int s_idle, int r_idle, int n);
        send_idle = s_idle;
        recv_idle = r_idle;
        for (int k = 0; k < 4; k++)
        begin
            wait_idle();
            for (int c = 0; c < 3; c++)
                if ($urandom_range(2) == 0)
                    load_curve(CH_W'(c));
            wait_idle();
            random_setting();
            random_traffic(n / 4);
        end
    endtask

    task automatic test_backpressure();
        send_idle = 0;
        recv_idle = 0;
        wait_idle();
        set_window(0, 65536);
        set_counts(NPTS, NPTS, NPTS);
        hold_cycles = 400;
        random_traffic(120);
        wait_idle();
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        samples.valid      = 1'b0;
        samples.command    = CMD_MAP;
        samples.sample     = '0;
        samples.sample_ok  = 1'b0;
        samples.channel    = CH_RED;
        samples.point_slot = '0;
        samples.point_x    = '0;
        samples.point_y    = '0;
        pixels.ready       = 1'b0;
        errors             = 0;
        cycles             = 0;
        hold_cycles        = 0;
        send_idle          = 0;
        recv_idle          = 0;
        win_lo             = 0;
        win_hi             = 65536;
        for (int c = 0; c < 3; c++)
        begin
            curve_len[c] = 0;
            for (int i = 0; i < NPTS; i++)
            begin
                knot_x[c][i] = 0;
                knot_y[c][i] = 0;
            end
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_phase(8, 79, 360);
        test_backpressure();
        test_random_phase(79, 8, 360);
        test_random_phase(0, 0, 360);
        wait_idle();

        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
